// File: hw/rtl/ip_address_text_parser_unit_defines.svh
`ifndef IP_ADDRESS_TEXT_PARSER_UNIT_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define IPTP_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define IPTP_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/iptp_pkg.sv
package iptp_pkg;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_V4     = 3'd1;
    localparam logic [2:0] PH_LEAD   = 3'd2;
    localparam logic [2:0] PH_TOK    = 3'd3;
    localparam logic [2:0] PH_GAPEND = 3'd4;
    localparam logic [2:0] PH_GROUP  = 3'd5;
    localparam logic [2:0] PH_ERR    = 3'd6;
    localparam logic [2:0] PH_UNSUP  = 3'd7;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_UNSUP  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic [1:0]        status;
        logic              v4;
        logic              tail;
        logic              gap;
        logic [3:0]        gap_pos;
        logic [3:0]        count;
        logic [31:0]       octets;
        logic [7:0][15:0]  groups;
    } t_fin;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] half0;
        logic [63:0] half1;
    } t_res;

endpackage

// File: hw/rtl/iptp_parse.sv
module iptp_parse
    import iptp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_ch,
    input  logic [1:0] i_family,
    output t_fin       o_fin
);

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_fam, n_fam;
    logic [15:0] r_grp [8];
    logic [15:0] n_grp [8];
    logic [3:0]  r_gi, n_gi;
    logic [15:0] r_hex, n_hex;
    logic [9:0]  r_dec, n_dec;
    logic [2:0]  r_dc, n_dc;
    logic        r_alldec, n_alldec;
    logic        r_gap, n_gap;
    logic [3:0]  r_gp, n_gp;
    logic [31:0] r_oct, n_oct;
    logic [1:0]  r_oi, n_oi;

    logic [2:0]  ph0;
    logic [1:0]  fam0;
    logic        is_dig, is_hex, is_term;
    logic [7:0]  lc;
    logic [3:0]  dval;
    logic [9:0]  dec_next;
    logic [4:0]  oct_sh;
    logic        dot_ok;
    logic [31:0] oct_end;
    logic [1:0]  st_end;

    always_comb begin
        lc       = i_ch | 8'h20;
        is_dig   = i_ch inside {[8'h30:8'h39]};
        is_hex   = is_dig || (lc inside {[8'h61:8'h66]});
        dval     = is_dig ? i_ch[3:0] : (lc[3:0] + 4'd9);
        is_term  = (i_ch == CH_NUL);
        dec_next = {r_dec[6:0], 3'b000} + {r_dec[8:0], 1'b0} + {6'd0, dval};
        oct_sh   = 5'd24 - {r_oi, 3'b000};
        dot_ok   = (r_gi < 4'd7) && ((r_gi >= 4'd6) || r_gap) && r_alldec &&
                   (r_dc >= 3'd1) && (r_dc <= 3'd3) && (r_dec <= 10'd255) &&
                   !((r_dc == 3'd2) && (r_dec < 10'd10)) &&
                   !((r_dc == 3'd3) && (r_dec < 10'd100));
        oct_end  = r_oct | {24'd0, r_dec[7:0]};
    end

    always_comb begin
        ph0  = r_phase;
        fam0 = r_fam;
        if (r_phase == PH_START) begin
            fam0 = i_family;
            if (i_family == FAM_V4) begin
                ph0 = PH_V4;
            end else if (i_family != FAM_V6) begin
                ph0 = PH_UNSUP;
            end
        end
    end

    // end-of-string status and final picture of the stores
    always_comb begin
        o_fin         = '0;
        o_fin.v4      = (fam0 == FAM_V4);
        o_fin.tail    = (ph0 == PH_V4);
        o_fin.gap     = r_gap;
        o_fin.gap_pos = r_gp;
        o_fin.count   = r_gi;
        o_fin.octets  = oct_end;
        for (int k = 0; k < 8; k++) begin
            o_fin.groups[k] = r_grp[k];
        end
        case (ph0)
            PH_UNSUP: begin
                st_end = ST_UNSUP;
            end
            PH_GAPEND: begin
                st_end = ST_OK;
            end
            PH_GROUP: begin
                st_end = (r_gap || (r_gi == 4'd7)) ? ST_OK : ST_BAD;
                o_fin.groups[r_gi[2:0]] = r_hex;
                o_fin.count = r_gi + 4'd1;
            end
            PH_V4: begin
                st_end = ((r_dc != 3'd0) && (r_dec <= 10'd255) && (r_oi == 2'd3)) ?
                         ST_OK : ST_BAD;
            end
            default: begin
                st_end = ST_BAD;
            end
        endcase
        o_fin.status = st_end;
    end

    always_comb begin
        n_phase  = ph0;
        n_fam    = fam0;
        for (int k = 0; k < 8; k++) begin
            n_grp[k] = r_grp[k];
        end
        n_gi     = r_gi;
        n_hex    = r_hex;
        n_dec    = r_dec;
        n_dc     = r_dc;
        n_alldec = r_alldec;
        n_gap    = r_gap;
        n_gp     = r_gp;
        n_oct    = r_oct;
        n_oi     = r_oi;
        if (is_term) begin
            n_phase  = PH_START;
            n_fam    = FAM_V4;
            for (int k = 0; k < 8; k++) begin
                n_grp[k] = '0;
            end
            n_gi     = '0;
            n_hex    = '0;
            n_dec    = '0;
            n_dc     = '0;
            n_alldec = 1'b1;
            n_gap    = 1'b0;
            n_gp     = '0;
            n_oct    = '0;
            n_oi     = '0;
        end else begin
            case (ph0)
                PH_V4: begin
                    if (is_dig) begin
                        if ((r_dc >= 3'd3) || ((r_dc == 3'd1) && (r_dec == 10'd0))) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_dec = dec_next;
                            n_dc  = r_dc + 3'd1;
                        end
                    end else if (i_ch == CH_DOT) begin
                        if ((r_dc == 3'd0) || (r_dec > 10'd255) || (r_oi >= 2'd3)) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_oct    = r_oct | ({24'd0, r_dec[7:0]} << oct_sh);
                            n_oi     = r_oi + 2'd1;
                            n_hex    = '0;
                            n_dec    = '0;
                            n_dc     = '0;
                            n_alldec = 1'b1;
                        end
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_START, PH_TOK, PH_GAPEND, PH_LEAD: begin
                    if ((i_ch == CH_COLON) && (ph0 == PH_START)) begin
                        n_phase = PH_LEAD;
                    end else if ((i_ch == CH_COLON) &&
                                 ((ph0 == PH_LEAD) || ((ph0 == PH_TOK) && !r_gap))) begin
                        n_gap            = 1'b1;
                        n_gp             = {1'b0, r_gi[2:0]};
                        n_grp[r_gi[2:0]] = '0;
                        n_gi             = r_gi + 4'd1;
                        n_phase          = PH_GAPEND;
                    end else if (is_hex && (ph0 != PH_LEAD) &&
                                 ((ph0 != PH_GAPEND) || (r_gi < 4'd8))) begin
                        n_hex    = {12'd0, dval};
                        n_dc     = 3'd1;
                        n_dec    = is_dig ? {6'd0, dval} : 10'd0;
                        n_alldec = is_dig;
                        n_phase  = PH_GROUP;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_GROUP: begin
                    if (is_hex) begin
                        if (r_dc >= 3'd4) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_hex = {r_hex[11:0], dval};
                            if (is_dig) begin
                                if (r_dc < 3'd3) begin
                                    n_dec = dec_next;
                                end
                            end else begin
                                n_alldec = 1'b0;
                            end
                            n_dc = r_dc + 3'd1;
                        end
                    end else if (i_ch == CH_COLON) begin
                        if (r_gi >= 4'd7) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_grp[r_gi[2:0]] = r_hex;
                            n_gi     = r_gi + 4'd1;
                            n_hex    = '0;
                            n_dec    = '0;
                            n_dc     = '0;
                            n_alldec = 1'b1;
                            n_phase  = PH_TOK;
                        end
                    end else if (i_ch == CH_DOT) begin
                        if (!dot_ok) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_grp[r_gi[2:0]]          = '0;
                            n_grp[r_gi[2:0] + 3'd1]   = '0;
                            n_gi     = r_gi + 4'd2;
                            n_oct    = {r_dec[7:0], 24'd0};
                            n_oi     = 2'd1;
                            n_hex    = '0;
                            n_dec    = '0;
                            n_dc     = '0;
                            n_alldec = 1'b1;
                            n_phase  = PH_V4;
                        end
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                default: begin
                    n_phase = ph0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_fam    <= FAM_V4;
            for (int k = 0; k < 8; k++) begin
                r_grp[k] <= '0;
            end
            r_gi     <= '0;
            r_hex    <= '0;
            r_dec    <= '0;
            r_dc     <= '0;
            r_alldec <= 1'b1;
            r_gap    <= 1'b0;
            r_gp     <= '0;
            r_oct    <= '0;
            r_oi     <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_fam    <= n_fam;
            for (int k = 0; k < 8; k++) begin
                r_grp[k] <= n_grp[k];
            end
            r_gi     <= n_gi;
            r_hex    <= n_hex;
            r_dec    <= n_dec;
            r_dc     <= n_dc;
            r_alldec <= n_alldec;
            r_gap    <= n_gap;
            r_gp     <= n_gp;
            r_oct    <= n_oct;
            r_oi     <= n_oi;
        end
    end

endmodule

// File: hw/rtl/iptp_assemble.sv
module iptp_assemble
    import iptp_pkg::*;
(
    input  t_fin i_fin,
    output t_res o_res
);

    logic [2:0]        last;
    logic [2:0]        shift;
    logic [3:0]        hi_start;
    logic [7:0][15:0]  w;

    always_comb begin
        last     = i_fin.count[2:0] - 3'd1;
        shift    = 3'd7 - last;
        hi_start = i_fin.gap_pos + {1'b0, shift};
        for (int k = 0; k < 8; k++) begin
            if (!i_fin.gap || (4'(k) < i_fin.gap_pos)) begin
                w[k] = i_fin.groups[k];
            end else if (4'(k) >= hi_start) begin
                w[k] = i_fin.groups[3'(k) - shift];
            end else begin
                w[k] = '0;
            end
        end
        if (i_fin.tail) begin
            w[6] = i_fin.octets[31:16];
            w[7] = i_fin.octets[15:0];
        end
        o_res.status = i_fin.status;
        o_res.half0  = '0;
        o_res.half1  = '0;
        if (i_fin.status == ST_OK) begin
            if (i_fin.v4) begin
                o_res.half0 = {i_fin.octets, 32'd0};
            end else begin
                o_res.half0 = {w[0], w[1], w[2], w[3]};
                o_res.half1 = {w[4], w[5], w[6], w[7]};
            end
        end
    end

endmodule

// File: hw/rtl/iptp_outbuf.sv
module iptp_outbuf
    import iptp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res        i_res,
    input  logic        i_stall,
    output logic        o_free,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_address_half,
    output logic        o_half_index,
    output logic        o_is_last
);

    logic        r_pend;
    logic        r_half;
    logic [1:0]  r_status;
    logic [63:0] r_h0;
    logic [63:0] r_h1;
    logic        take;

    assign take           = r_pend && !i_stall;
    assign o_free         = !r_pend || (r_half && !i_stall);
    assign o_valid        = r_pend;
    assign o_status       = r_status;
    assign o_address_half = r_half ? r_h1 : r_h0;
    assign o_half_index   = r_half;
    assign o_is_last      = r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_half <= 1'b0;
        end else if (i_load) begin
            r_pend <= 1'b1;
            r_half <= 1'b0;
        end else if (take) begin
            r_pend <= !r_half;
            r_half <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_res.status;
            r_h0     <= i_res.half0;
            r_h1     <= i_res.half1;
        end
    end

endmodule

// File: hw/rtl/ip_address_text_parser_unit.sv
// IPv4/IPv6 address text parser. Feed one character per word, family on the
// first word of a string, and a zero character to end it. Each string ends in
// two output words: bytes 0..7 then bytes 8..15, both with the same status.
// The block takes one character per cycle while o_stall is low; a character
// passes an input register, then one pass of parse and assembly logic into
// the result register, which a terminator loads as it leaves the input
// register. A terminator waits in the input register until the result
// register is empty or its last word leaves in that cycle, so a terminator
// passes only once the previous string's second word has left.
module ip_address_text_parser_unit
    import iptp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic [1:0]  i_family,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_address_half,
    output logic        o_half_index,
    output logic        o_is_last
);

    logic       r_in_vld;
    logic [7:0] r_ch;
    logic [1:0] r_fam;
    logic       out_free;
    logic       adv;
    logic       term;
    t_fin       fin;
    t_res       res;

    assign term    = (r_ch == CH_NUL);
    assign adv     = r_in_vld && (!term || out_free);
    assign o_stall = r_in_vld && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_ch  <= i_ch;
            r_fam <= i_family;
        end
    end

    iptp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_ch     (r_ch),
        .i_family (r_fam),
        .o_fin    (fin)
    );

    iptp_assemble u_asm (
        .i_fin (fin),
        .o_res (res)
    );

    iptp_outbuf u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (adv && term),
        .i_res          (res),
        .i_stall        (i_stall),
        .o_free         (out_free),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_address_half (o_address_half),
        .o_half_index   (o_half_index),
        .o_is_last      (o_is_last)
    );

endmodule

// File: hw/rtl/iptp_checker.sv
`include "ip_address_text_parser_unit_defines.svh"

module iptp_checker
    import iptp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [63:0] o_address_half,
    input logic        o_half_index,
    input logic        o_is_last
);

    `IPTP_ASSERT_NOW(a_last_is_second, o_valid, o_is_last == o_half_index, "is_last mismatch")
    `IPTP_ASSERT_NEXT(a_pair_follows, o_valid && !o_half_index && !i_stall, o_valid && o_half_index, "second word missing")
    `IPTP_ASSERT_NEXT(a_pair_status, o_valid && !o_half_index && !i_stall, o_status == $past(o_status), "status differs in pair")
    `IPTP_ASSERT_NOW(a_fail_zero, o_valid && (o_status != ST_OK), o_address_half == 64'd0, "failed address not zero")
    `IPTP_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_address_half) && $stable(o_half_index), "stalled word changed")

endmodule

bind ip_address_text_parser_unit iptp_checker u_iptp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_address_half (o_address_half),
    .o_half_index   (o_half_index),
    .o_is_last      (o_is_last)
);

// File: tb/ip_address_text_parser_unit_tb.sv
module ip_address_text_parser_unit_tb;
    import iptp_pkg::*;

    localparam logic [1:0] FAM_UNSUP = 2'd2;
    localparam logic [1:0] FAM_RSVD  = 2'd3;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_F = "f";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_CHARS = 800;
    localparam int CALM_CHARS   = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] half;
        logic        half_idx;
        logic        last;
    } t_addr_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_ch = 8'd0;
    logic [1:0]  i_family = 2'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_address_half;
    logic        o_half_index;
    logic        o_is_last;

    ip_address_text_parser_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_family       (i_family),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_address_half (o_address_half),
        .o_half_index   (o_half_index),
        .o_is_last      (o_is_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // parser state mirror
    logic [2:0]  ps_phase;
    logic [1:0]  ps_family;
    logic [15:0] ps_groups [8];
    logic [3:0]  ps_gidx;
    logic [15:0] ps_hex;
    logic [9:0]  ps_dec;
    logic [2:0]  ps_digits;
    logic        ps_alldec;
    logic        ps_gap;
    logic [3:0]  ps_gap_pos;
    logic [31:0] ps_octets;
    logic [1:0]  ps_oidx;

    t_addr_word  words_due [$];
    t_addr_word  word_want;
    logic [7:0]  line_buf [$];

    bit idle_on = 1'b1;
    bit hold_off_req = 1'b0;
    int fail_count = 0;
    int chars_sent = 0;
    int strings_sent = 0;
    int words_checked = 0;
    int n_ok = 0;
    int n_bad = 0;
    int n_unsup = 0;

    function automatic bit is_dec(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int hex_val(logic [7:0] c);
        logic [7:0] lc;
        lc = c | CASE_BIT;
        if (is_dec(c)) return int'(c - CH_ZERO);
        if (lc >= CH_LOW_A && lc <= CH_LOW_F) return int'(lc - CH_LOW_A) + 10;
        return -1;
    endfunction

    task automatic clear_digits();
        ps_hex = '0;
        ps_dec = '0;
        ps_digits = '0;
        ps_alldec = 1'b1;
    endtask

    task automatic clear_string();
        ps_phase = PH_START;
        ps_family = FAM_V4;
        for (int k = 0; k < 8; k++) ps_groups[k] = '0;
        ps_gidx = '0;
        clear_digits();
        ps_gap = 1'b0;
        ps_gap_pos = '0;
        ps_octets = '0;
        ps_oidx = '0;
    endtask

    task automatic start_group(logic [7:0] c, int d);
        clear_digits();
        ps_hex = 16'(d);
        ps_digits = 3'd1;
        if (is_dec(c)) ps_dec = 10'(d);
        else ps_alldec = 1'b0;
        ps_phase = PH_GROUP;
    endtask

    task automatic take_gap();
        ps_gap = 1'b1;
        ps_gap_pos = {1'b0, ps_gidx[2:0]};
        ps_groups[ps_gidx[2:0]] = '0;
        ps_gidx++;
        ps_phase = PH_GAPEND;
    endtask

    task automatic v4_char(logic [7:0] c);
        if (is_dec(c)) begin
            if (ps_digits >= 3 || (ps_digits == 1 && ps_dec == 0)) begin
                ps_phase = PH_ERR;
            end else begin
                ps_dec = 10'(ps_dec * 10 + (c - CH_ZERO));
                ps_digits++;
            end
        end else if (c == CH_DOT) begin
            if (ps_digits == 0 || ps_dec > 255 || ps_oidx >= 3) begin
                ps_phase = PH_ERR;
            end else begin
                ps_octets = ps_octets | ({22'd0, ps_dec} << (24 - 8 * ps_oidx));
                ps_oidx++;
                clear_digits();
            end
        end else begin
            ps_phase = PH_ERR;
        end
    endtask

    task automatic group_char(logic [7:0] c);
        int d;
        bit ok;
        logic [3:0] gi;
        d = hex_val(c);
        gi = ps_gidx;
        if (d >= 0) begin
            if (ps_digits >= 4) begin
                ps_phase = PH_ERR;
            end else begin
                ps_hex = {ps_hex[11:0], 4'(d)};
                if (is_dec(c)) begin
                    if (ps_digits < 3) ps_dec = 10'(ps_dec * 10 + d);
                end else begin
                    ps_alldec = 1'b0;
                end
                ps_digits++;
            end
        end else if (c == CH_COLON) begin
            if (gi >= 7) begin
                ps_phase = PH_ERR;
            end else begin
                ps_groups[gi[2:0]] = ps_hex;
                ps_gidx++;
                clear_digits();
                ps_phase = PH_TOK;
            end
        end else if (c == CH_DOT) begin
            ok = gi < 7 && (gi >= 6 || ps_gap) && ps_alldec &&
                 ps_digits >= 1 && ps_digits <= 3 && ps_dec <= 255 &&
                 !(ps_digits == 2 && ps_dec < 10) &&
                 !(ps_digits == 3 && ps_dec < 100);
            if (!ok) begin
                ps_phase = PH_ERR;
            end else begin
                ps_groups[gi[2:0]] = '0;
                ps_groups[gi[2:0] + 3'd1] = '0;
                ps_gidx = gi + 4'd2;
                ps_octets = {ps_dec[7:0], 24'd0};
                ps_oidx = 2'd1;
                clear_digits();
                ps_phase = PH_V4;
            end
        end else begin
            ps_phase = PH_ERR;
        end
    endtask

    task automatic end_status(output logic [1:0] st);
        case (ps_phase)
            PH_UNSUP: st = ST_UNSUP;
            PH_GAPEND: st = ST_OK;
            PH_GROUP: begin
                if (!(ps_gap || ps_gidx == 7)) begin
                    st = ST_BAD;
                end else begin
                    ps_groups[ps_gidx[2:0]] = ps_hex;
                    ps_gidx++;
                    st = ST_OK;
                end
            end
            PH_V4: begin
                if (ps_digits == 0 || ps_dec > 255 || ps_oidx != 3) begin
                    st = ST_BAD;
                end else begin
                    ps_octets = ps_octets | {22'd0, ps_dec};
                    st = ST_OK;
                end
            end
            default: st = ST_BAD;
        endcase
    endtask

    task automatic finish_string(logic [1:0] st);
        logic [15:0] w [8];
        logic [63:0] h0;
        logic [63:0] h1;
        int last;
        int shift;
        h0 = '0;
        h1 = '0;
        if (st == ST_OK) begin
            if (ps_family == FAM_V4) begin
                h0 = {ps_octets, 32'd0};
            end else begin
                last = (int'(ps_gidx) - 1) & 7;
                shift = 7 - last;
                for (int k = 0; k < 8; k++) begin
                    w[k] = '0;
                    if (!ps_gap || k < ps_gap_pos) w[k] = ps_groups[k];
                    else if (k >= ps_gap_pos + shift) w[k] = ps_groups[(k - shift) & 7];
                end
                if (ps_phase == PH_V4) begin
                    w[6] = ps_octets[31:16];
                    w[7] = ps_octets[15:0];
                end
                h0 = {w[0], w[1], w[2], w[3]};
                h1 = {w[4], w[5], w[6], w[7]};
            end
        end
        words_due.push_back('{status: st, half: h0, half_idx: 1'b0, last: 1'b0});
        words_due.push_back('{status: st, half: h1, half_idx: 1'b1, last: 1'b1});
        clear_string();
    endtask

    task automatic parse_char(logic [7:0] c, logic [1:0] f);
        logic [1:0] st;
        int d;
        if (ps_phase == PH_START) begin
            ps_family = f;
            if (f == FAM_V4) ps_phase = PH_V4;
            else if (f != FAM_V6) ps_phase = PH_UNSUP;
        end
        if (c == CH_NUL) begin
            end_status(st);
            finish_string(st);
        end else begin
            d = hex_val(c);
            case (ps_phase)
                PH_V4: v4_char(c);
                PH_START: begin
                    if (c == CH_COLON) ps_phase = PH_LEAD;
                    else if (d >= 0) start_group(c, d);
                    else ps_phase = PH_ERR;
                end
                PH_LEAD: begin
                    if (c == CH_COLON) take_gap();
                    else ps_phase = PH_ERR;
                end
                PH_TOK: begin
                    if (c == CH_COLON && !ps_gap) take_gap();
                    else if (d >= 0) start_group(c, d);
                    else ps_phase = PH_ERR;
                end
                PH_GAPEND: begin
                    if (d >= 0 && ps_gidx < 8) start_group(c, d);
                    else ps_phase = PH_ERR;
                end
                PH_GROUP: group_char(c);
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (words_due.size() == 0) begin
                $error("address word with none pending: status %0d half %h",
                       o_status, o_address_half);
                fail_count++;
            end else begin
                word_want = words_due.pop_front();
                words_checked++;
                if (o_status != word_want.status) begin
                    $error("status: expected %0d, got %0d", word_want.status, o_status);
                    fail_count++;
                end
                if (o_address_half != word_want.half) begin
                    $error("address_half: expected %h, got %h",
                           word_want.half, o_address_half);
                    fail_count++;
                end
                if (o_half_index != word_want.half_idx) begin
                    $error("half_index: expected %0d, got %0d",
                           word_want.half_idx, o_half_index);
                    fail_count++;
                end
                if (o_is_last != word_want.last) begin
                    $error("is_last: expected %0d, got %0d", word_want.last, o_is_last);
                    fail_count++;
                end
                if (word_want.last) begin
                    if (word_want.status == ST_OK) n_ok++;
                    else if (word_want.status == ST_BAD) n_bad++;
                    else n_unsup++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 16)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("ip_address_text_parser_unit: mismatch");
        $finish;
    end

    task automatic send_char(logic [7:0] c, logic [1:0] f);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        i_family <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_char(c, f);
        chars_sent++;
    endtask

    // family counts only on the first word; the rest carry noise there
    task automatic send_line(logic [1:0] fam);
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == 0 ? fam : 2'($urandom_range(0, 3)));
        send_char(CH_NUL, line_buf.size() == 0 ? fam : 2'($urandom_range(0, 3)));
        strings_sent++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic send_text(string s, logic [1:0] fam);
        line_buf.delete();
        add_text(s);
        send_line(fam);
    endtask

    function automatic logic [7:0] hex_char(int n, bit up);
        if (n < 10) return CH_ZERO + 8'(n);
        return (up ? CH_UP_A : CH_LOW_A) + 8'(n - 10);
    endfunction

    task automatic add_hex_group();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            line_buf.push_back(hex_char($urandom_range(0, 15), 1'($urandom_range(0, 1))));
    endtask

    task automatic add_v4_quad();
        int v;
        for (int i = 0; i < 4; i++) begin
            if (i > 0) line_buf.push_back(CH_DOT);
            case ($urandom_range(0, 9))
                0: v = 0;
                1: v = 255;
                2: v = $urandom_range(256, 999);
                default: v = $urandom_range(0, 255);
            endcase
            add_text($sformatf("%0d", v));
        end
    endtask

    task automatic add_v6();
        int slots;
        int lft;
        int rgt;
        bit gap;
        bit tail;
        gap = $urandom_range(0, 2) != 0;
        tail = $urandom_range(0, 4) == 0;
        slots = tail ? 6 : 8;
        if (gap) begin
            lft = $urandom_range(0, slots - 1);
            rgt = $urandom_range(0, slots - 1 - lft);
        end else begin
            lft = slots;
            rgt = 0;
        end
        for (int i = 0; i < lft; i++) begin
            if (i > 0) line_buf.push_back(CH_COLON);
            add_hex_group();
        end
        if (gap) add_text("::");
        for (int i = 0; i < rgt; i++) begin
            if (i > 0) line_buf.push_back(CH_COLON);
            add_hex_group();
        end
        if (tail) begin
            if (rgt > 0 || (!gap && lft > 0)) line_buf.push_back(CH_COLON);
            add_v4_quad();
        end
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        pool = ":.0123456789abcdefABCDEFgz/ ";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic mutate_line();
        int pos;
        if (line_buf.size() == 0) begin
            line_buf.push_back(pick_char());
        end else begin
            pos = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: line_buf[pos] = pick_char();
                1: line_buf.delete(pos);
                2: line_buf.insert(pos, pick_char());
                default: line_buf[pos] = 8'($urandom_range(1, 255));
            endcase
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic reset_dut();
        clear_string();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_ipv4_text();
        send_text("0.0.0.0", FAM_V4);
        send_text("255.255.255.255", FAM_V4);
        send_text("192.168.1.10", FAM_V4);
        send_text("256.0.0.1", FAM_V4);
        send_text("01.1.1.1", FAM_V4);
        send_text("1.2.3", FAM_V4);
        send_text("1.2.3.4.5", FAM_V4);
        send_text("1..2.3", FAM_V4);
        send_text("1234.1.1.1", FAM_V4);
        send_text("", FAM_V4);
    endtask

    task automatic test_ipv6_text();
        send_text("::", FAM_V6);
        send_text("::1", FAM_V6);
        send_text("1::", FAM_V6);
        send_text("FFFF:ffff:0:1:abcd:EF01:2345:6789", FAM_V6);
        send_text("1:2:3:4:5:6:7:8:9", FAM_V6);
        send_text("1:2:3:4:5:6:7", FAM_V6);
        send_text("1::2::3", FAM_V6);
        send_text(":1", FAM_V6);
        send_text("12345::1", FAM_V6);
        send_text("::ffff:192.0.2.1", FAM_V6);
        send_text("1:2:3:4:5:6:1.2.3.4", FAM_V6);
        send_text("1:2:3:4:5:1.2.3.4", FAM_V6);
        send_text("::01.2.3.4", FAM_V6);
        send_text("1:::2", FAM_V6);
        send_text("", FAM_V6);
    endtask

    task automatic test_family_codes();
        send_text("1.2.3.4", FAM_UNSUP);
        send_text("::1", FAM_RSVD);
        send_text("", FAM_UNSUP);
    endtask

    task automatic test_noise();
        for (int i = 0; i < 12; i++) begin
            line_buf.delete();
            add_noise();
            send_line(2'($urandom_range(0, 3)));
        end
    endtask

    // stall the output long enough that the block backs up into its input
    task automatic test_output_hold();
        hold_off_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            line_buf.delete();
            add_v6();
            send_line(FAM_V6);
        end
        send_text("10.0.0.1", FAM_V4);
    endtask

    task automatic test_random_text();
        int first;
        int kind;
        logic [1:0] fam;
        first = chars_sent;
        while (chars_sent - first < RANDOM_CHARS) begin
            if (chars_sent - first >= RANDOM_CHARS - CALM_CHARS) idle_on = 1'b0;
            line_buf.delete();
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                add_v6();
                fam = FAM_V6;
            end else if (kind < 14) begin
                add_v4_quad();
                fam = FAM_V4;
            end else if (kind < 16) begin
                add_noise();
                fam = 2'($urandom_range(0, 3));
            end else if (kind < 17) begin
                add_v6();
                fam = $urandom_range(0, 1) ? FAM_UNSUP : FAM_RSVD;
            end else if (kind < 18) begin
                fam = 2'($urandom_range(0, 3));
            end else if (kind < 19) begin
                add_v6();
                fam = FAM_V4;
            end else begin
                add_v4_quad();
                fam = FAM_V6;
            end
            if (kind < 14 && $urandom_range(0, 3) == 0) begin
                mutate_line();
                if ($urandom_range(0, 1)) mutate_line();
            end
            send_line(fam);
        end
    endtask

    initial begin
        reset_dut();
        test_ipv4_text();
        wait_drained();
        test_ipv6_text();
        wait_drained();
        test_family_codes();
        wait_drained();
        test_noise();
        wait_drained();
        test_output_hold();
        wait_drained();
        test_random_text();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (words_due.size() != 0) begin
            $error("%0d address words never arrived", words_due.size());
            fail_count++;
        end
        $display("covered %0d characters in %0d strings, %0d address words checked",
                 chars_sent, strings_sent, words_checked);
        $display("outcomes: %0d parsed, %0d malformed, %0d unsupported family",
                 n_ok, n_bad, n_unsup);
        if (fail_count == 0) begin
            $display("ip_address_text_parser_unit: match");
        end else begin
            $display("ip_address_text_parser_unit: mismatch");
        end
        $finish;
    end

endmodule
